// ----- hdl/radial_sor_point_update_assert.svh -----
// Assertion macros for the radial SOR point update block.
// Used by the port checker; no other dependencies.
`ifndef RADIAL_SOR_POINT_UPDATE_ASSERT_SVH
`define RADIAL_SOR_POINT_UPDATE_ASSERT_SVH

// same-cycle implication
`define RSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsp check failed: same-cycle rule");

// next-cycle implication
`define RSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsp check failed: next-cycle rule");

`endif

// ----- hdl/rsp_pkg.sv -----
// Shared types, constants and saturation helper for the radial SOR update.
// No dependencies.
package rsp_pkg;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   localparam logic [17:0] W_RESET = 18'h1_0000;   // 1.0 in Q2.16

   localparam int DIV_STEPS  = 32;                 // quotient bits, one per stage
   localparam int DIV_LAT    = DIV_STEPS + 2;      // input reg + steps + output reg
   localparam int MUL_LAT    = 4;                  // src*db*da/2 chain
   localparam int PIPE_DEPTH = 2 * DIV_LAT + 8;    // stages before the output register

   typedef struct packed {
      logic              ovf;
      logic signed [31:0] val;
   } qsat_type;

   typedef struct packed {
      logic signed [31:0] vl;
      logic signed [31:0] vc;
      logic signed [31:0] vr;
      logic signed [31:0] src;
      logic [30:0]        db;
      logic [30:0]        da;
      logic [30:0]        r;
      logic               fixed;
      logic               ends;
   } item_type;

   typedef struct packed {
      logic signed [31:0] vl;
      logic signed [31:0] vc;
      logic signed [31:0] vr;
      logic               fixed;
      logic               ends;
   } base_type;

   typedef struct packed {
      base_type           base;
      logic signed [31:0] t1;
      logic               flag;
   } side_type;

   function automatic qsat_type sat64(input logic signed [63:0] x);
      qsat_type r;
      if (x > 64'(Q_MAX)) begin
         r.ovf = 1'b1;
         r.val = Q_MAX;
      end else if (x < 64'(Q_MIN)) begin
         r.ovf = 1'b1;
         r.val = Q_MIN;
      end else begin
         r.ovf = 1'b0;
         r.val = x[31:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/rsp_delay.sv -----
// Enabled delay line for side data that rides along the dividers.
// Depends on nothing.
module rsp_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_i,
   output logic [WIDTH-1:0] q_o
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q_o = tap_ff[DEPTH-1];

endmodule

// ----- hdl/rsp_div.sv -----
// Pipelined Q16.16 divider: floor((n << 16) / d), saturating, one quotient bit per stage.
// Depends on rsp_pkg.
module rsp_div (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] num_i,
   input  logic signed [31:0] den_i,
   input  logic               flag_i,
   output logic signed [31:0] quo_o,
   output logic               flag_o
);
   import rsp_pkg::*;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] work;   // dividend bits out at the top, quotient bits in at the bottom
      logic [31:0] dmag;
      logic        neg;
      logic        ovf;
      logic        flag;
   } div_stage_type;

   div_stage_type      st_ff [DIV_STEPS+1];
   div_stage_type      st0_in;
   logic [31:0]        n_mag;
   logic [31:0]        d_mag;
   logic signed [31:0] quo_ff, quo_in;
   logic               flag_ff, flag_in;
   logic [32:0]        neg_mag;
   logic               rem_nz;

   assign n_mag = num_i[31] ? (~num_i + 32'd1) : num_i;
   assign d_mag = den_i[31] ? (~den_i + 32'd1) : den_i;

   always_comb begin
      st0_in.rem  = {16'd0, n_mag[31:16]};
      st0_in.work = {n_mag[15:0], 16'd0};
      st0_in.dmag = d_mag;
      st0_in.neg  = num_i[31] ^ den_i[31];
      // quotient would need 33+ bits; also covers a zero divisor
      st0_in.ovf  = {16'd0, n_mag[31:16]} >= d_mag;
      st0_in.flag = flag_i;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st0_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [32:0]   trial;
      logic          ge;
      div_stage_type step_in;

      assign trial = {st_ff[k].rem, st_ff[k].work[31]};
      assign ge    = trial >= {1'b0, st_ff[k].dmag};

      always_comb begin
         step_in      = st_ff[k];
         step_in.rem  = ge ? 32'(trial - {1'b0, st_ff[k].dmag}) : trial[31:0];
         step_in.work = {st_ff[k].work[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k+1] <= step_in;
         end
      end
   end

   assign rem_nz  = |st_ff[DIV_STEPS].rem;
   assign neg_mag = {1'b0, st_ff[DIV_STEPS].work} + {32'd0, rem_nz};

   always_comb begin
      flag_in = st_ff[DIV_STEPS].flag;
      if (st_ff[DIV_STEPS].ovf) begin
         quo_in  = st_ff[DIV_STEPS].neg ? Q_MIN : Q_MAX;
         flag_in = 1'b1;
      end else if (!st_ff[DIV_STEPS].neg) begin
         if (st_ff[DIV_STEPS].work[31]) begin
            quo_in  = Q_MAX;
            flag_in = 1'b1;
         end else begin
            quo_in = st_ff[DIV_STEPS].work;
         end
      end else begin
         // negative: floor means rounding the magnitude up
         if (neg_mag > 33'h0_8000_0000) begin
            quo_in  = Q_MIN;
            flag_in = 1'b1;
         end else begin
            quo_in = 32'(~neg_mag + 33'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff  <= quo_in;
         flag_ff <= flag_in;
      end
   end

   assign quo_o  = quo_ff;
   assign flag_o = flag_ff;

endmodule

// ----- hdl/radial_sor_point_update.sv -----
// Top level of the radial SOR point update: stencil, blend, clamp.
// Depends on rsp_pkg, rsp_div, rsp_delay.
//
//   channel   ports        dir   per beat
//   req       req_*        in    one grid point (potentials, steps, radius, flags)
//   rsp       rsp_*        out   updated potential and status bits
//   csr       csr_wr_*     in    relaxation factor, written at once
//
// One point enters per cycle while req_ready is high; the pipe from accept to
// rsp_valid runs through two 34-stage dividers in series (stencil terms, then num/den).
// Reset is synchronous and clears the valid bits and the factor (to 1.0).
// A stalled rsp beat holds the whole pipe unless the stage feeding the output
// register is empty, in which case the pipe keeps filling.
module radial_sor_point_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_v_left,
   input  logic signed [31:0] req_v_center,
   input  logic signed [31:0] req_v_right,
   input  logic signed [31:0] req_source_term,
   input  logic [30:0]        req_step_below,
   input  logic [30:0]        req_step_above,
   input  logic [30:0]        req_radius,
   input  logic               req_point_fixed,
   input  logic               req_ends_equal,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_potential,
   output logic               rsp_depleted,
   output logic               rsp_point_updated,
   output logic               rsp_saturated,
   input  logic               csr_wr_en,
   input  logic [17:0]        csr_wr_data
);
   import rsp_pkg::*;

   logic [17:0]          w_ff;
   logic [PIPE_DEPTH:1]  vld_ff;
   logic                 adv, en_out;

   item_type             in_ff;
   // src*db*da/2 chain
   logic signed [63:0]   prod1_ff, prod2_ff;
   logic [30:0]          da2_ff, da3_ff;
   qsat_type             p_ff, t1_ff, t1_in;
   logic                 pflag4_ff;
   // stencil terms
   qsat_type             gdiff;
   logic signed [31:0]   q_g, q_r, q_l, q_ib, q_ia;
   logic                 f_g, f_r, f_l, f_ib, f_ia;
   logic [32:0]          t1_d;
   base_type             base_d;
   qsat_type             num1, den1, num2;
   qsat_type             num1_ff, den_ff, num_ff, den37_ff;
   logic signed [31:0]   ql_ff;
   side_type             side36_ff, side37_ff, side_d;
   logic [$bits(side_type)-1:0] side_q;
   logic [$bits(base_type)-1:0] base_q;
   logic signed [31:0]   q_s;
   logic                 f_s;
   // blend
   qsat_type             s_in, delta_in, m_in, v_in;
   side_type             side72_ff, side73_ff, side74_ff, side75_ff, side76_ff;
   logic signed [31:0]   s_ff, delta_ff, m_ff, v_ff;
   logic signed [63:0]   prod3_ff;
   // output
   logic signed [31:0]   lo, hi, res;
   logic                 dep;
   logic                 rsp_valid_ff;
   logic signed [31:0]   pot_ff;
   logic                 dep_ff, upd_ff, sat_ff;

   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign adv       = en_out || !vld_ff[PIPE_DEPTH];
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= W_RESET;
      end else if (csr_wr_en) begin
         w_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= '{vl: req_v_left, vc: req_v_center, vr: req_v_right,
                    src: req_source_term, db: req_step_below, da: req_step_above,
                    r: req_radius, fixed: req_point_fixed, ends: req_ends_equal};
      end
   end

   // ---- product chain, stages 2..5
   assign t1_in = sat64(prod2_ff >>> 17);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod1_ff  <= $signed(in_ff.src) * $signed({1'b0, in_ff.db});
         da2_ff    <= in_ff.da;
         p_ff      <= sat64(prod1_ff >>> 16);
         da3_ff    <= da2_ff;
         prod2_ff  <= p_ff.val * $signed({1'b0, da3_ff});
         pflag4_ff <= p_ff.ovf;
         t1_ff     <= '{ovf: t1_in.ovf | pflag4_ff, val: t1_in.val};
      end
   end

   rsp_delay #(.WIDTH(33), .DEPTH(DIV_LAT - MUL_LAT)) u_t1_dly (
      .clock(clock), .en(adv), .d_i(t1_ff), .q_o(t1_d));

   // ---- first divider bank, stages 2..35
   assign gdiff = sat64(64'(in_ff.vr) - 64'(in_ff.vl));

   rsp_div u_div_g (.clock(clock), .en(adv), .num_i(gdiff.val),
      .den_i($signed({1'b0, in_ff.r})), .flag_i(gdiff.ovf), .quo_o(q_g), .flag_o(f_g));
   rsp_div u_div_r (.clock(clock), .en(adv), .num_i(in_ff.vr),
      .den_i($signed({1'b0, in_ff.da})), .flag_i(1'b0), .quo_o(q_r), .flag_o(f_r));
   rsp_div u_div_l (.clock(clock), .en(adv), .num_i(in_ff.vl),
      .den_i($signed({1'b0, in_ff.db})), .flag_i(1'b0), .quo_o(q_l), .flag_o(f_l));
   rsp_div u_div_ib (.clock(clock), .en(adv), .num_i(Q_ONE),
      .den_i($signed({1'b0, in_ff.db})), .flag_i(1'b0), .quo_o(q_ib), .flag_o(f_ib));
   rsp_div u_div_ia (.clock(clock), .en(adv), .num_i(Q_ONE),
      .den_i($signed({1'b0, in_ff.da})), .flag_i(1'b0), .quo_o(q_ia), .flag_o(f_ia));

   rsp_delay #(.WIDTH($bits(base_type)), .DEPTH(DIV_LAT)) u_base_dly (
      .clock(clock), .en(adv),
      .d_i({in_ff.vl, in_ff.vc, in_ff.vr, in_ff.fixed, in_ff.ends}), .q_o(base_q));
   assign base_d = base_type'(base_q);

   // ---- combine, stages 36..37
   assign num1 = sat64(64'(q_g) + 64'(q_r));
   assign den1 = sat64(64'(q_ib) + 64'(q_ia));
   assign num2 = sat64(64'(num1_ff.val) + 64'(ql_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         num1_ff   <= num1;
         den_ff    <= den1;
         ql_ff     <= q_l;
         side36_ff <= '{base: base_d, t1: t1_d[31:0],
                        flag: t1_d[32] | f_g | f_r | f_l | f_ib | f_ia | num1.ovf | den1.ovf};
         num_ff    <= num2;
         den37_ff  <= den_ff;
         side37_ff <= '{base: side36_ff.base, t1: side36_ff.t1,
                        flag: side36_ff.flag | num1_ff.ovf | num2.ovf};
      end
   end

   // ---- num/den, stages 38..71
   rsp_div u_div_s (.clock(clock), .en(adv), .num_i(num_ff.val), .den_i(den37_ff.val),
      .flag_i(side37_ff.flag), .quo_o(q_s), .flag_o(f_s));

   rsp_delay #(.WIDTH($bits(side_type)), .DEPTH(DIV_LAT)) u_side_dly (
      .clock(clock), .en(adv), .d_i(side37_ff), .q_o(side_q));
   assign side_d = side_type'(side_q);

   // ---- blend, stages 72..76
   assign s_in     = sat64(64'(side_d.t1) + 64'(q_s));
   assign delta_in = sat64(64'(s_ff) - 64'(side72_ff.base.vc));
   assign m_in     = sat64(prod3_ff >>> 16);
   assign v_in     = sat64(64'(side75_ff.base.vc) + 64'(m_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff      <= s_in.val;
         side72_ff <= '{base: side_d.base, t1: side_d.t1, flag: f_s | s_in.ovf};
         delta_ff  <= delta_in.val;
         side73_ff <= '{base: side72_ff.base, t1: side72_ff.t1,
                        flag: side72_ff.flag | delta_in.ovf};
         prod3_ff  <= $signed({1'b0, w_ff}) * delta_ff;
         side74_ff <= side73_ff;
         m_ff      <= m_in.val;
         side75_ff <= '{base: side74_ff.base, t1: side74_ff.t1,
                        flag: side74_ff.flag | m_in.ovf};
         v_ff      <= v_in.val;
         side76_ff <= '{base: side75_ff.base, t1: side75_ff.t1,
                        flag: side75_ff.flag | v_in.ovf};
      end
   end

   // ---- clamp to neighbor range (skipped when ends are equal), output register
   assign lo = (side76_ff.base.vl < side76_ff.base.vr) ? side76_ff.base.vl : side76_ff.base.vr;
   assign hi = (side76_ff.base.vl < side76_ff.base.vr) ? side76_ff.base.vr : side76_ff.base.vl;

   always_comb begin
      if (v_ff < lo) begin
         res = lo;
         dep = 1'b0;
      end else if (v_ff > hi) begin
         res = hi;
         dep = 1'b0;
      end else begin
         res = v_ff;
         dep = 1'b1;
      end
      if (side76_ff.base.ends) begin
         res = v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= vld_ff[PIPE_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         if (side76_ff.base.fixed) begin
            pot_ff <= side76_ff.base.vc;
            dep_ff <= 1'b0;
            upd_ff <= 1'b0;
            sat_ff <= 1'b0;
         end else begin
            pot_ff <= res;
            dep_ff <= dep;
            upd_ff <= 1'b1;
            sat_ff <= side76_ff.flag;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_potential = pot_ff;
   assign rsp_depleted      = dep_ff;
   assign rsp_point_updated = upd_ff;
   assign rsp_saturated     = sat_ff;

endmodule

// ----- hdl/rsp_chk.sv -----
// Port-level checker for the radial SOR point update, bound to the top level.
// Depends on radial_sor_point_update_assert.svh.
`include "radial_sor_point_update_assert.svh"

module rsp_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_new_potential,
   input logic               rsp_depleted,
   input logic               rsp_point_updated,
   input logic               rsp_saturated
);

   // a held beat stays valid and keeps its potential, depleted and saturated bits
   `RSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_new_potential) && $stable(rsp_depleted) && $stable(rsp_saturated))

   // output register empties on reset
   `RSP_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // fixed points report no status
   `RSP_ASSERT_NOW(a_fixed_quiet, clock, reset, rsp_valid && !rsp_point_updated,
      !rsp_depleted && !rsp_saturated)

   // free output means the input is open
   `RSP_ASSERT_NOW(a_no_false_stall, clock, reset, !rsp_valid || rsp_ready, req_ready)

endmodule

bind radial_sor_point_update rsp_chk u_rsp_chk (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_new_potential(rsp_new_potential),
   .rsp_depleted(rsp_depleted), .rsp_point_updated(rsp_point_updated),
   .rsp_saturated(rsp_saturated));
